/* rtl/abc_pkg.sv */
// ----------------------------------------------------------------------------
// abc_pkg
// Shared widths, register indexes, reset values and controller/datapath
// command and status types of the affine byte cipher.
// ----------------------------------------------------------------------------
package abc_pkg;

  // field and internal widths
  localparam int unsigned DATA_W    = 8;   // byte fields, key registers
  localparam int unsigned MOD_W     = 9;   // modulus, remainders, Euclid residues
  localparam int unsigned PROD_W    = 17;  // widest dividend: inverse times shifted byte
  localparam int unsigned COEF_W    = 10;  // signed Bezout coefficient
  localparam int unsigned CNT_W     = 5;   // divider step counter, holds PROD_W
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd2;

  // reset values of the configuration registers
  localparam logic [DATA_W-1:0] KEY_MULT_RST   = 8'd3;
  localparam logic [DATA_W-1:0] KEY_OFFSET_RST = 8'd5;
  localparam logic [MOD_W-1:0]  MODULUS_RST    = 9'd256;

  // legal range of the modulus
  localparam logic [MOD_W-1:0] MOD_MIN = 9'd2;
  localparam logic [MOD_W-1:0] MOD_MAX = 9'd256;

  // operation codes of the kind field
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // operand selection for the shared divider
  typedef enum logic [2:0] {
    DIV_SRC_ENC,   // key_mult * byte + key_offset, by the modulus
    DIV_SRC_AMOD,  // key_mult by the modulus
    DIV_SRC_BMOD,  // key_offset by the modulus
    DIV_SRC_EUC,   // one Euclid step, r0 by r1
    DIV_SRC_PROD   // inverse times shifted byte, by the modulus
  } div_src_t;

  // controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     div_go;
    div_src_t div_src;
    logic     cap_a;
    logic     cap_b;
    logic     euc_upd;
    logic     fix;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind;
    logic div_done;
    logic r1_zero;
    logic r0_one;
  } dp_stat_t;

  // register value clamped into the legal modulus range
  function automatic logic [MOD_W-1:0] eff_modulus(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] res;
    begin
      if (m < MOD_MIN) begin
        res = MOD_MIN;
      end else if (m > MOD_MAX) begin
        res = MOD_MAX;
      end else begin
        res = m;
      end
      return res;
    end
  endfunction

endpackage

/* rtl/abc_if.sv */
// ----------------------------------------------------------------------------
// abc_if
// Valid/ready channels of the affine byte cipher: input beats and result beats.
// ----------------------------------------------------------------------------
interface abc_in_if import abc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface abc_out_if import abc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              key_error;

  modport source (output valid, output data_out, output key_error, input ready);
  modport sink   (input valid, input data_out, input key_error, output ready);
endinterface

/* rtl/abc_div.sv */
// ----------------------------------------------------------------------------
// abc_div
// Restoring divider, one quotient bit per cycle. Short operations take a
// 9-bit dividend and 9 steps, long ones a 17-bit dividend and 17 steps.
// ----------------------------------------------------------------------------
module abc_div import abc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              short_op,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MOD_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quot,
  output logic [MOD_W-1:0]  rem
);

  logic [PROD_W-1:0] dq_r, dq_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MOD_W:0]    shifted;
  logic [MOD_W:0]    trial;

  // partial remainder with the next dividend bit brought down
  assign shifted = {rem_r, dq_r[PROD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  // step logic
  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == CNT_W'(1));
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      if (short_op) begin
        dq_nxt  = {dividend[MOD_W-1:0], {(PROD_W-MOD_W){1'b0}}};
        cnt_nxt = CNT_W'(MOD_W);
      end else begin
        dq_nxt  = dividend;
        cnt_nxt = CNT_W'(PROD_W);
      end
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial[MOD_W-1:0];
        dq_nxt  = {dq_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[MOD_W-1:0];
        dq_nxt  = {dq_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

/* rtl/abc_dp.sv */
// ----------------------------------------------------------------------------
// abc_dp
// Datapath: configuration registers, item registers, extended Euclid
// registers, inverse fix-up, operand selection for the shared divider and
// the result register.
// ----------------------------------------------------------------------------
module abc_dp import abc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_wdata,
  input  logic                 in_kind,
  input  logic [DATA_W-1:0]    in_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [DATA_W-1:0]    out_data,
  output logic                 out_err
);

  logic [DATA_W-1:0]        key_mult_r, key_offset_r;
  logic [MOD_W-1:0]         modulus_r;
  logic                     kind_r;
  logic [DATA_W-1:0]        x_r;
  logic [MOD_W-1:0]         r0_r, r1_r;
  logic signed [COEF_W-1:0] s0_r, s1_r;
  logic [MOD_W-1:0]         d_r;
  logic [DATA_W-1:0]        inv_r;
  logic                     err_r;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_err_r;

  logic [MOD_W-1:0]           n_eff;
  logic [2*DATA_W-1:0]        enc_prod;
  logic [PROD_W-1:0]          dec_prod;
  logic [PROD_W-1:0]          div_dividend;
  logic [MOD_W-1:0]           div_divisor;
  logic                       div_short;
  logic                       div_done;
  logic [PROD_W-1:0]          div_quot;
  logic [MOD_W-1:0]           div_rem;
  logic [MOD_W:0]             d_sum;
  logic signed [2*COEF_W-1:0] qs;
  logic signed [COEF_W-1:0]   s_step;
  logic signed [COEF_W:0]     s_ext, n_ext, s_pos, s_red;

  assign n_eff = eff_modulus(modulus_r);

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mult_r   <= KEY_MULT_RST;
      key_offset_r <= KEY_OFFSET_RST;
      modulus_r    <= MODULUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_MULT:   key_mult_r   <= cfg_wdata[DATA_W-1:0];
        REG_KEY_OFFSET: key_offset_r <= cfg_wdata[DATA_W-1:0];
        REG_MODULUS:    modulus_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier products feeding the divider
  assign enc_prod = {{DATA_W{1'b0}}, key_mult_r} * {{DATA_W{1'b0}}, x_r};
  assign dec_prod = {{MOD_W{1'b0}}, inv_r} * {{DATA_W{1'b0}}, d_r};

  // divider operand selection
  always_comb begin
    div_dividend = '0;
    div_divisor  = n_eff;
    div_short    = 1'b1;
    case (cmd.div_src)
      DIV_SRC_ENC: begin
        div_dividend = PROD_W'(enc_prod) + PROD_W'(key_offset_r);
        div_short    = 1'b0;
      end
      DIV_SRC_AMOD: div_dividend = PROD_W'(key_mult_r);
      DIV_SRC_BMOD: div_dividend = PROD_W'(key_offset_r);
      DIV_SRC_EUC: begin
        div_dividend = PROD_W'(r0_r);
        div_divisor  = r1_r;
      end
      DIV_SRC_PROD: begin
        div_dividend = dec_prod;
        div_short    = 1'b0;
      end
      default: ;
    endcase
  end

  abc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .short_op (div_short),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // ciphertext minus the reduced offset plus the modulus, always positive
  assign d_sum = {2'b00, x_r} + {1'b0, n_eff} - {1'b0, div_rem};

  // Euclid coefficient step, true value stays within the modulus
  assign qs     = $signed({1'b0, div_quot[MOD_W-1:0]}) * s1_r;
  assign s_step = s0_r - $signed(qs[COEF_W-1:0]);

  // bring the final coefficient into 0 .. n-1
  assign s_ext = {s0_r[COEF_W-1], s0_r};
  assign n_ext = {2'b00, n_eff};
  assign s_pos = s0_r[COEF_W-1] ? (s_ext + n_ext) : s_ext;
  assign s_red = (s_pos >= n_ext) ? (s_pos - n_ext) : s_pos;

  // item and Euclid registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      x_r    <= in_data;
      err_r  <= 1'b0;
    end
    if (cmd.cap_a) begin
      r0_r <= n_eff;
      r1_r <= div_rem;
      s0_r <= '0;
      s1_r <= COEF_W'(1);
    end
    if (cmd.cap_b) begin
      d_r <= d_sum[MOD_W-1:0];
    end
    if (cmd.euc_upd) begin
      r0_r <= r1_r;
      r1_r <= div_rem;
      s0_r <= s1_r;
      s1_r <= s_step;
    end
    if (cmd.fix) begin
      err_r <= (r0_r != MOD_W'(1));
      inv_r <= s_red[DATA_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= err_r ? '0 : div_rem[DATA_W-1:0];
      out_err_r  <= err_r;
    end
  end

  assign stat.kind     = kind_r;
  assign stat.div_done = div_done;
  assign stat.r1_zero  = (r1_r == '0);
  assign stat.r0_one   = (r0_r == MOD_W'(1));

  assign out_data = out_data_r;
  assign out_err  = out_err_r;

endmodule

/* rtl/abc_ctrl.sv */
// ----------------------------------------------------------------------------
// abc_ctrl
// Controller: sequences the divider through the encrypt or decrypt recipe
// and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module abc_ctrl import abc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_START   = 11'b000_0000_0010,
    ST_ENC_WT  = 11'b000_0000_0100,
    ST_AMOD_WT = 11'b000_0000_1000,
    ST_BMOD_WT = 11'b000_0001_0000,
    ST_EUC_CHK = 11'b000_0010_0000,
    ST_EUC_WT  = 11'b000_0100_0000,
    ST_FIX     = 11'b000_1000_0000,
    ST_PROD_GO = 11'b001_0000_0000,
    ST_PROD_WT = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_START;
        end
      end
      ST_START: begin
        cmd.div_go = 1'b1;
        if (stat.kind == KIND_DECRYPT) begin
          cmd.div_src = DIV_SRC_AMOD;
          state_nxt   = ST_AMOD_WT;
        end else begin
          cmd.div_src = DIV_SRC_ENC;
          state_nxt   = ST_ENC_WT;
        end
      end
      ST_ENC_WT: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_AMOD_WT: begin
        // take a mod n and start b mod n at once
        if (stat.div_done) begin
          cmd.cap_a   = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_src = DIV_SRC_BMOD;
          state_nxt   = ST_BMOD_WT;
        end
      end
      ST_BMOD_WT: begin
        if (stat.div_done) begin
          cmd.cap_b = 1'b1;
          state_nxt = ST_EUC_CHK;
        end
      end
      ST_EUC_CHK: begin
        if (stat.r1_zero) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_src = DIV_SRC_EUC;
          state_nxt   = ST_EUC_WT;
        end
      end
      ST_EUC_WT: begin
        if (stat.div_done) begin
          cmd.euc_upd = 1'b1;
          state_nxt   = ST_EUC_CHK;
        end
      end
      ST_FIX: begin
        // gcd other than one ends the item with a key error
        cmd.fix = 1'b1;
        if (stat.r0_one) begin
          state_nxt = ST_PROD_GO;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PROD_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_src = DIV_SRC_PROD;
        state_nxt   = ST_PROD_WT;
      end
      ST_PROD_WT: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result beat held until taken
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/affine_byte_cipher_unit.sv */
// ----------------------------------------------------------------------------
// affine_byte_cipher_unit
// Affine cipher on bytes with configurable multiplier, offset and modulus.
// ----------------------------------------------------------------------------
// Encrypt beats give (a*x + b) mod N, decrypt beats give inv(a)*(y - b) mod N
// with the inverse found by extended Euclid; a decrypt whose multiplier shares
// a factor with N returns 0 with key_error set. One item is worked on at a
// time, but a new beat is taken while the previous result still waits in the
// output register. Every step runs on one shared bit-serial divider (one
// quotient bit per cycle), so the item time is set by its passes: encrypt
// takes one pass, decrypt one each for a mod N and b mod N, one per Euclid
// step (at most 11 for N up to 256) and a final product pass; a decrypt
// that ends in a key error skips the final product pass.
// Configuration registers (0 key_mult, 1 key_offset, 2 modulus) are to be
// written only while no item is in flight, which the block does not enforce;
// modulus values below 2 act as 2 and values above 256 act as 256.
module affine_byte_cipher_unit import abc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  abc_in_if.sink               in_ch,
  abc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  abc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and registers
  abc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_kind   (in_ch.kind),
    .in_data   (in_ch.data_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_ch.data_out),
    .out_err   (out_ch.key_error)
  );

endmodule

/* rtl/abc_check.sv */
// ----------------------------------------------------------------------------
// abc_check
// Port-level checks of the affine byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module abc_check import abc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DATA_W-1:0]    data_out,
  input logic                 key_error,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [MOD_W-1:0]     cfg_wdata
);

  logic [MOD_W-1:0] mod_r;
  logic [1:0]       pend_r, pend_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items accepted but not yet delivered
  assign pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};

  // shadow of the modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= MODULUS_RST;
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_we && (cfg_index == REG_MODULUS)) begin
        mod_r <= cfg_wdata;
      end
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(key_error))
    else $error("result beat changed while stalled");

  // key error always comes with a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_error |-> data_out == '0)
    else $error("key error with nonzero data");

  // result lies below the effective modulus
  a_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, data_out} < eff_modulus(mod_r))
    else $error("result not below modulus");

  // no result without an item in flight
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without accepted item");

  // at most one item in work beside one waiting result
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r != 2'd2)
    else $error("input taken with two items outstanding");

endmodule

bind affine_byte_cipher_unit abc_check u_abc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .key_error (out_ch.key_error),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

/* test/affine_byte_cipher_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_byte_cipher_unit_tb
// Self-checking bench for the affine byte cipher unit. Input beats are driven
// on the valid/ready channel. Every accepted beat is run through an affine
// map and extended-Euclid model of the block under the current key. The
// predicted byte and key error flag are queued and compared with each
// result beat. Keys are changed between phases once the block has drained.
// ----------------------------------------------------------------------------
module affine_byte_cipher_unit_tb;
  import abc_pkg::*;

  // index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned PHASES = 13;
  localparam int unsigned BYTES_PER_PHASE = 100;
  localparam int unsigned TAIL_CYCLES = 200;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              key_error;
  } cipher_result_t;

  // key copy, affine model and queue of awaited result beats
  class cipher_scoreboard;
    logic [DATA_W-1:0] mult_reg;
    logic [DATA_W-1:0] offset_reg;
    logic [MOD_W-1:0]  modulus_reg;
    cipher_result_t    awaited_results[$];
    int unsigned       failures;

    function new();
      mult_reg    = KEY_MULT_RST;
      offset_reg  = KEY_OFFSET_RST;
      modulus_reg = MODULUS_RST;
      failures    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] value);
      case (idx)
        REG_KEY_MULT:   mult_reg    = value[DATA_W-1:0];
        REG_KEY_OFFSET: offset_reg  = value[DATA_W-1:0];
        REG_MODULUS:    modulus_reg = value;
        default: ;
      endcase
    endfunction

    // affine map or its inverse under the current key
    function cipher_result_t affine_transform(logic kind, logic [DATA_W-1:0] x);
      cipher_result_t res;
      int unsigned n, a, b, inv;
      int r0, r1, s0, s1, q, t;
      n = modulus_reg;
      if (n < 2) n = 2;
      if (n > 256) n = 256;
      a = mult_reg % n;
      b = offset_reg % n;
      res.data_out  = '0;
      res.key_error = 1'b0;
      if (kind == KIND_ENCRYPT) begin
        res.data_out = DATA_W'((a * x + b) % n);
      end else begin
        // extended euclid, s tracks the coefficient of a
        r0 = n;
        r1 = a;
        s0 = 0;
        s1 = 1;
        while (r1 != 0) begin
          q  = r0 / r1;
          t  = r0 - q * r1;
          r0 = r1;
          r1 = t;
          t  = s0 - q * s1;
          s0 = s1;
          s1 = t;
        end
        if (r0 != 1) begin
          res.key_error = 1'b1;
        end else begin
          s0 = s0 % int'(n);
          if (s0 < 0) s0 = s0 + int'(n);
          inv = s0;
          res.data_out = DATA_W'((inv * (x + n - b)) % n);
        end
      end
      return res;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void note_input(logic kind, logic [DATA_W-1:0] x);
      awaited_results.push_back(affine_transform(kind, x));
    endfunction

    function void check_result(logic [DATA_W-1:0] data_out, logic key_error);
      cipher_result_t exp;
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result beat data_out=%0d key_error=%0b",
                               data_out, key_error));
        return;
      end
      exp = awaited_results.pop_front();
      if (exp.data_out !== data_out || exp.key_error !== key_error)
        note_failure($sformatf("data_out exp %0d got %0d, key_error exp %0b got %0b",
                               exp.data_out, data_out, exp.key_error, key_error));
    endfunction

    function void flush_leftovers();
      cipher_result_t exp;
      while (awaited_results.size() != 0) begin
        exp = awaited_results.pop_front();
        note_failure($sformatf("result never came: data_out=%0d key_error=%0b",
                               exp.data_out, exp.key_error));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MOD_W-1:0]     cfg_wdata;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  cipher_scoreboard     sb;

  abc_in_if  in_ch ();
  abc_out_if out_ch ();

  affine_byte_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #1 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data_out, out_ch.key_error);
  end

  // hang guard
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // one input beat, entered and left at a falling edge
  task automatic send_byte(input logic kind, input logic [DATA_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.data_in <= x;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, x);
    @(negedge clk);
  endtask

  // stop sending and wait for every awaited result
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
  endtask

  // write all three key registers, optionally a stray index first
  task automatic program_key(input logic [MOD_W-1:0] mult, input logic [MOD_W-1:0] offset,
                             input logic [MOD_W-1:0] modulus, input bit stray);
    logic [MOD_W-1:0] junk;
    drain();
    if (stray) begin
      junk = MOD_W'($urandom_range(511));
      cfg_we    <= 1'b1;
      cfg_index <= REG_NONE;
      cfg_wdata <= junk;
      sb.write_reg(REG_NONE, junk);
      @(negedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_MULT;
    cfg_wdata <= mult;
    sb.write_reg(REG_KEY_MULT, mult);
    @(negedge clk);
    cfg_index <= REG_KEY_OFFSET;
    cfg_wdata <= offset;
    sb.write_reg(REG_KEY_OFFSET, offset);
    @(negedge clk);
    cfg_index <= REG_MODULUS;
    cfg_wdata <= modulus;
    sb.write_reg(REG_MODULUS, modulus);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [MOD_W-1:0] pick_modulus();
    logic [MOD_W-1:0] m;
    case ($urandom_range(9))
      0:       m = MOD_MIN;
      1:       m = MOD_MAX;
      2:       m = MOD_W'($urandom_range(1));
      3:       m = MOD_W'($urandom_range(511, 257));
      4:       m = MOD_W'($urandom_range(511));
      default: m = MOD_W'($urandom_range(256, 2));
    endcase
    return m;
  endfunction

  function automatic logic [MOD_W-1:0] pick_mult();
    logic [MOD_W-1:0] a;
    case ($urandom_range(7))
      0:       a = '0;
      1:       a = MOD_W'(1);
      2:       a = MOD_W'(255);
      default: a = MOD_W'($urandom_range(511));
    endcase
    return a;
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte();
    logic [DATA_W-1:0] x;
    case ($urandom_range(7))
      0:       x = '0;
      1:       x = '1;
      default: x = DATA_W'($urandom_range(255));
    endcase
    return x;
  endfunction

  // corners of the key and data space
  task automatic run_directed;
    // reset key
    send_byte(KIND_ENCRYPT, 8'd0);
    send_byte(KIND_ENCRYPT, 8'd255);
    send_byte(KIND_DECRYPT, 8'd0);
    send_byte(KIND_DECRYPT, 8'd255);
    send_byte(KIND_ENCRYPT, 8'hA5);
    send_byte(KIND_DECRYPT, 8'h5A);
    // upper data bit of key writes masked, modulus above range
    program_key(9'h1FF, 9'h1FF, 9'd511, 1'b1);
    send_byte(KIND_ENCRYPT, 8'd255);
    send_byte(KIND_DECRYPT, 8'd0);
    send_byte(KIND_DECRYPT, 8'd255);
    // zero multiplier, modulus zero acts as two
    program_key(9'd0, 9'd0, 9'd0, 1'b0);
    send_byte(KIND_ENCRYPT, 8'd1);
    send_byte(KIND_DECRYPT, 8'd1);
    send_byte(KIND_ENCRYPT, 8'd128);
    // modulus one, multiplier reduces to zero
    program_key(9'd4, 9'd1, 9'd1, 1'b0);
    send_byte(KIND_DECRYPT, 8'd0);
    send_byte(KIND_ENCRYPT, 8'd3);
    // key and data above a small modulus
    program_key(9'd200, 9'd250, 9'd7, 1'b0);
    send_byte(KIND_ENCRYPT, 8'd255);
    send_byte(KIND_DECRYPT, 8'd255);
    send_byte(KIND_DECRYPT, 8'd6);
    // common factor with nonzero multiplier
    program_key(9'd6, 9'd0, 9'd9, 1'b0);
    send_byte(KIND_DECRYPT, 8'd8);
    send_byte(KIND_ENCRYPT, 8'd8);
    // fibonacci pair, longest euclid run
    program_key(9'd144, 9'd0, 9'd233, 1'b0);
    send_byte(KIND_DECRYPT, 8'd200);
    send_byte(KIND_DECRYPT, 8'd255);
  endtask

  // stimulus
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_ENCRYPT;
    in_ch.data_in  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb = new();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    // random phases, idling pattern rotates
    for (int p = 0; p < PHASES; p++) begin
      program_key(pick_mult(), MOD_W'($urandom_range(511)), pick_modulus(),
                  ($urandom_range(3) == 0));
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int i = 0; i < BYTES_PER_PHASE; i++) begin
        // sender holds off until the block is empty
        if (p == 5 && i == BYTES_PER_PHASE / 2) drain();
        send_byte(1'($urandom_range(1)), pick_byte());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.flush_leftovers();
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/abc_pkg.sv
rtl/abc_if.sv
rtl/abc_div.sv
rtl/abc_dp.sv
rtl/abc_ctrl.sv
rtl/affine_byte_cipher_unit.sv
rtl/abc_check.sv
test/affine_byte_cipher_unit_tb.sv
